// ----- sv/pas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Shared codes and types for the positional array store: request codes,
// status codes, the decoded operation and the queued request word.
// ----------------------------------------------------------------------------
package pas_pkg;

   // request type codes as they arrive on the port
   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_INSERT = 3'd1;
   localparam logic [2:0] REQ_DELETE = 3'd2;
   localparam logic [2:0] REQ_SEARCH = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_BAD     = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam int POS_W = 7;
   localparam int VAL_W = 32;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4,
      OP_BAD    = 3'd5
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   value;
   } item_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage
`default_nettype wire

// ----- sv/pas_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/pas_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pas_front
// Request intake: decode the request type and hold words in a two-entry
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module pas_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_type,
   input  logic [6:0]          req_position,
   input  logic signed [31:0]  req_value,
   input  logic                pop,
   output pas_pkg::head_type   head
);

   pas_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       do_pop;
   pas_pkg::op_type op;

   always_comb begin
      unique case (req_type)
         pas_pkg::REQ_CLEAR:  op = pas_pkg::OP_CLEAR;
         pas_pkg::REQ_INSERT: op = pas_pkg::OP_INSERT;
         pas_pkg::REQ_DELETE: op = pas_pkg::OP_DELETE;
         pas_pkg::REQ_SEARCH: op = pas_pkg::OP_SEARCH;
         pas_pkg::REQ_READ:   op = pas_pkg::OP_READ;
         default:             op = pas_pkg::OP_BAD;
      endcase
   end

   assign busy   = (cnt_ff == 2'd2);
   assign push   = start && !busy;
   assign do_pop = pop && (cnt_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff].op       <= op;
         q_ff[wr_ptr_ff].position <= req_position;
         q_ff[wr_ptr_ff].value    <= req_value;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- sv/pas_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pas_back
// Request execution: bounds checks against the fill count, entry moves
// for insert and delete, linear search and reads, all through the RAM.
// ----------------------------------------------------------------------------
module pas_back #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  pas_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_fill_count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;
   localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(DEPTH);
   localparam logic [CMP_W-1:0]  ONE_C   = CMP_W'(1);
   localparam logic [ADDR_W-1:0] ONE_A   = ADDR_W'(1);
   localparam logic [CNT_W-1:0]  ONE_N   = CNT_W'(1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_USE  = 4'b0100,
      S_PUT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   pas_pkg::item_type cur_ff, cur_in;
   pas_pkg::item_type work;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_rdval_ff, rsp_rdval_in;
   logic [6:0]  rsp_fill_ff, rsp_fill_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       wr_data, rd_data;

   logic [CMP_W-1:0]  pos_ext, cnt_ext, idx_ext, pos_m1_ext, cnt_m1_ext, found_ext;
   logic [CMP_W-1:0]  fill_ext;
   logic [ADDR_W-1:0] pos_m1;
   logic              pos_ok, ins_ok, at_last, at_pos;

   pas_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign work       = (state_ff == S_IDLE) ? head.item : cur_ff;
   assign pos_ext    = CMP_W'(work.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign idx_ext    = CMP_W'(idx_ff);
   assign pos_m1_ext = pos_ext - ONE_C;
   assign cnt_m1_ext = cnt_ext - ONE_C;
   assign found_ext  = idx_ext + ONE_C;
   assign pos_m1     = pos_m1_ext[ADDR_W-1:0];
   assign pos_ok     = (pos_ext >= ONE_C) && (pos_ext <= cnt_ext);
   assign ins_ok     = (cnt_ext < DEPTH_C) && (pos_ext >= ONE_C)
                       && (pos_ext <= cnt_ext + ONE_C);
   assign at_last    = (idx_ext == cnt_m1_ext);
   assign at_pos     = (idx_ext == pos_m1_ext);
   assign rd_en      = (state_ff == S_READ);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rsp_valid_in = 1'b0;
      rsp_status_in = pas_pkg::ST_DONE;
      rsp_found_in = 7'd0;
      rsp_rdval_in = 32'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cur_in = head.item;
               unique case (work.op)
                  pas_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  pas_pkg::OP_INSERT: begin
                     if (!ins_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pas_pkg::ST_BAD;
                     end else if (pos_ext == cnt_ext + ONE_C) begin
                        state_in = S_PUT;
                     end else begin
                        idx_in   = cnt_m1_ext[ADDR_W-1:0];
                        state_in = S_READ;
                     end
                  end
                  pas_pkg::OP_DELETE: begin
                     if (!pos_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pas_pkg::ST_BAD;
                     end else if (pos_ext == cnt_ext) begin
                        count_in     = count_ff - ONE_N;
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = pos_ext[ADDR_W-1:0];
                        state_in = S_READ;
                     end
                  end
                  pas_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pas_pkg::ST_MISSING;
                     end else begin
                        idx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  pas_pkg::OP_READ: begin
                     if (pos_ok) begin
                        idx_in   = pos_m1;
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pas_pkg::ST_BAD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pas_pkg::ST_BAD;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_USE;
         end
         S_USE: begin
            state_in = S_READ;
            unique case (work.op)
               pas_pkg::OP_INSERT: begin
                  // move one entry up, walking down toward the insert slot
                  wr_en   = 1'b1;
                  wr_addr = idx_ff + ONE_A;
                  if (at_pos) begin
                     state_in = S_PUT;
                  end else begin
                     idx_in = idx_ff - ONE_A;
                  end
               end
               pas_pkg::OP_DELETE: begin
                  // move one entry down, walking up toward the tail
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - ONE_A;
                  if (at_last) begin
                     count_in     = count_ff - ONE_N;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     idx_in = idx_ff + ONE_A;
                  end
               end
               pas_pkg::OP_SEARCH: begin
                  if (rd_data == work.value) begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = found_ext[6:0];
                     state_in     = S_IDLE;
                  end else if (at_last) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pas_pkg::ST_MISSING;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in = idx_ff + ONE_A;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_rdval_in = rd_data;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_PUT: begin
            wr_en        = 1'b1;
            wr_addr      = pos_m1;
            wr_data      = work.value;
            count_in     = count_ff + ONE_N;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign fill_ext    = CMP_W'(count_in);
   assign rsp_fill_in = fill_ext[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_rdval_ff  <= rsp_rdval_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_read_value     = rsp_rdval_ff;
   assign rsp_fill_count     = rsp_fill_ff;

endmodule
`default_nettype wire

// ----- sv/positional_array_store_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_store_core
// Flow: clear, rejected requests, search on an empty list and delete of the
//   last entry finish from idle without a RAM access; read does one RAM
//   read; search reads entries from the front until a match or the end;
//   insert at p shifts entries p..count up; delete shifts p+1..count down.
// Throughput: one request per back-end run; every moved or compared entry
//   costs a RAM read then a write or compare. Results cannot be stalled.
// Reset: synchronous, empties the queue and the list; RAM is not cleared.
// ----------------------------------------------------------------------------
module positional_array_store_core #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   // result side, one-cycle strobe
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_fill_count
);

   // queue head handed from intake to execution
   pas_pkg::head_type head;
   logic              pop;

   // intake: decode and hold up to two words
   pas_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .pop          (pop),
      .head         (head)
   );

   // execution: owns the list RAM, the fill count and the result register
   pas_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_value     (rsp_read_value),
      .rsp_fill_count     (rsp_fill_count)
   );

   // queue comes out of reset empty, so intake is open
   a_open_after_reset: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   // fill count never exceeds the list depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((DEPTH > 127) || (rsp_fill_count <= DEPTH)))
      else $error("fill count above depth");

   // a miss carries neither position nor data
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pas_pkg::ST_MISSING))
      |-> ((rsp_found_position == 7'd0) && (rsp_read_value == 32'sd0)))
      else $error("miss with payload");

   // a reported match is always a success
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_found_position != 7'd0))
      |-> (rsp_status == pas_pkg::ST_DONE))
      else $error("match without done status");

endmodule
`default_nettype wire
